// File: rtl/dq_pkg.sv
// shared widths, codes and control types for the double-ended queue
package dq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int ITEM_W   = 32;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_BACK  = 3'd0,
        FUNC_PUSH_FRONT = 3'd1,
        FUNC_POP_BACK   = 3'd2,
        FUNC_POP_FRONT  = 3'd3,
        FUNC_READ       = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
        logic sel;
    } t_cell_ctrl;

endpackage

// File: rtl/dq_if.sv
// request and response channel interfaces of the double-ended queue
interface dq_req_if;
    logic                              valid;
    logic                              ready;
    logic [dq_pkg::FUNC_W-1:0]         func;
    logic [dq_pkg::VALUE_W-1:0]        value;
    logic signed [dq_pkg::POS_W-1:0]   position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink (input valid, input func, input value, input position, output ready);
endinterface

interface dq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [dq_pkg::ITEM_W-1:0]         item;
    logic [dq_pkg::OCC_W-1:0]          occupancy;
    logic [dq_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output item, output occupancy, output status, input ready);
    modport sink (input valid, input item, input occupancy, input status, output ready);
endinterface

// File: rtl/dq_cell.sv
// one storage cell of the shifting queue row
module dq_cell #(
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  dq_pkg::t_cell_ctrl    i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tap
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_value;
        end else if (i_ctrl.take_left) begin
            n_data = i_left;
        end else if (i_ctrl.take_right) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = i_ctrl.sel ? r_data : '0;

endmodule

// File: rtl/double_ended_queue.sv
// double-ended queue top level: row of shifting cells, count and response register
// response beat is registered at accept; throughput: one request per cycle while the
// response is not stalled; every operation settles in a single pass of the cell row
// response register is freed in the cycle its beat is taken, so no bubble under flow
// reset clears the count and the response valid; cell contents are not reset
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_req_if.sink   i_req,
    dq_rsp_if.source o_rsp
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int AW0 = (CW > 6) ? CW : 6;
    localparam int AW  = AW0 + 1;

    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;
    logic                           r_valid;
    logic [dq_pkg::ITEM_W-1:0]      r_item;
    logic [dq_pkg::OCC_W-1:0]       r_occ;
    dq_pkg::t_status                r_status;
    dq_pkg::t_status                n_status;

    logic                           accept;
    logic                           add_back;
    logic                           add_front;
    logic                           take_front;
    logic                           sel_en;
    logic [AW-1:0]                  target;
    logic [AW-1:0]                  count_ext;
    logic [AW-1:0]                  mag;
    logic [DATA_WIDTH-1:0]          value_dw;
    logic [DATA_WIDTH-1:0]          rd_data;

    logic [DATA_WIDTH-1:0]          cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]          cell_tap  [DEPTH];
    dq_pkg::t_cell_ctrl             cell_ctrl [DEPTH];

    assign accept    = i_req.valid && i_req.ready;
    assign i_req.ready = i_rst_n && (!r_valid || o_rsp.ready);
    assign count_ext = AW'(r_count);
    assign value_dw  = DATA_WIDTH'(i_req.value);
    assign mag       = AW'(7'd32 - {2'b00, i_req.position});

    always_comb begin
        n_count    = r_count;
        n_status   = dq_pkg::STATUS_OK;
        add_back   = 1'b0;
        add_front  = 1'b0;
        take_front = 1'b0;
        sel_en     = 1'b0;
        target     = '0;
        case (dq_pkg::t_func'(i_req.func))
            dq_pkg::FUNC_PUSH_BACK: begin
                if (r_count == CW'(DEPTH)) begin
                    n_status = dq_pkg::STATUS_FULL;
                end else begin
                    add_back = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            dq_pkg::FUNC_PUSH_FRONT: begin
                if (r_count == CW'(DEPTH)) begin
                    n_status = dq_pkg::STATUS_FULL;
                end else begin
                    add_front = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            dq_pkg::FUNC_POP_BACK: begin
                if (r_count == '0) begin
                    n_status = dq_pkg::STATUS_EMPTY;
                end else begin
                    sel_en  = 1'b1;
                    target  = count_ext - 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            dq_pkg::FUNC_POP_FRONT: begin
                if (r_count == '0) begin
                    n_status = dq_pkg::STATUS_EMPTY;
                end else begin
                    sel_en     = 1'b1;
                    take_front = 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            dq_pkg::FUNC_READ: begin
                if (!i_req.position[dq_pkg::POS_W-1]) begin
                    if (AW'(i_req.position[dq_pkg::POS_W-2:0]) >= count_ext) begin
                        n_status = dq_pkg::STATUS_RANGE;
                    end else begin
                        sel_en = 1'b1;
                        target = AW'(i_req.position[dq_pkg::POS_W-2:0]);
                    end
                end else begin
                    if (mag > count_ext) begin
                        n_status = dq_pkg::STATUS_RANGE;
                    end else begin
                        sel_en = 1'b1;
                        target = count_ext - mag;
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] left;
            logic [DATA_WIDTH-1:0] right;

            if (gi == 0) begin : g_first
                assign left = '0;
            end else begin : g_mid_l
                assign left = cell_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right = '0;
            end else begin : g_mid_r
                assign right = cell_data[gi+1];
            end

            assign cell_ctrl[gi].load = accept &&
                ((add_back && count_ext == AW'(gi)) || (add_front && gi == 0));
            assign cell_ctrl[gi].take_left  = accept && add_front && gi != 0;
            assign cell_ctrl[gi].take_right = accept && take_front;
            assign cell_ctrl[gi].sel        = sel_en && target == AW'(gi);

            dq_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctrl (cell_ctrl[gi]),
                .i_value(value_dw),
                .i_left (left),
                .i_right(right),
                .o_data (cell_data[gi]),
                .o_tap  (cell_tap[gi])
            );
        end
    endgenerate

    // taps are zero except at the selected cell
    always_comb begin
        rd_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_data = rd_data | cell_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_item   <= dq_pkg::ITEM_W'(rd_data);
            r_occ    <= dq_pkg::OCC_W'(n_count);
            r_status <= n_status;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.item      = r_item;
    assign o_rsp.occupancy = r_occ;
    assign o_rsp.status    = r_status;

endmodule

// File: rtl/dq_checker.sv
// port-level assertions for the double-ended queue and their binding
module dq_checker #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [dq_pkg::ITEM_W-1:0]     i_rsp_item,
    input logic [dq_pkg::OCC_W-1:0]      i_rsp_occupancy,
    input logic [dq_pkg::STATUS_W-1:0]   i_rsp_status
);

    // error beats carry no item
    a_err_item_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != dq_pkg::STATUS_OK |-> i_rsp_item == '0)
        else $error("error beat with nonzero item");

    // empty pop reports an empty queue
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == dq_pkg::STATUS_EMPTY |-> i_rsp_occupancy == '0)
        else $error("empty status with nonzero occupancy");

    // full push reports a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == dq_pkg::STATUS_FULL
        |-> i_rsp_occupancy == dq_pkg::OCC_W'(DEPTH))
        else $error("full status with wrong occupancy");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_item)
        && $stable(i_rsp_occupancy) && $stable(i_rsp_status))
        else $error("stalled response beat changed");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH(DEPTH)
) u_dq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_item     (o_rsp.item),
    .i_rsp_occupancy(o_rsp.occupancy),
    .i_rsp_status   (o_rsp.status)
);

// File: bench/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the double-ended queue: directed table, then random traffic
module double_ended_queue_tb;

    localparam int DEPTH           = dq_pkg::DEPTH_DEF;
    localparam int FUNC_W          = dq_pkg::FUNC_W;
    localparam int VALUE_W         = dq_pkg::VALUE_W;
    localparam int POS_W           = dq_pkg::POS_W;
    localparam int ITEM_W          = dq_pkg::ITEM_W;
    localparam int OCC_W           = dq_pkg::OCC_W;
    localparam int SLOT_W          = $clog2(DEPTH);
    localparam int DIRECTED_ROWS   = 24;
    localparam int ITEMS_PER_PHASE = 667;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 8;
    localparam int REPORT_LIMIT    = 10;
    localparam int EXPECT_DEPTH    = 4096;
    localparam longint TIMEOUT_NS  = 1_000_000;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

    localparam int MIX_FILL    = 0;
    localparam int MIX_DRAIN   = 1;
    localparam int MIX_BALANCE = 2;

    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic [OCC_W-1:0]  occupancy;
        dq_pkg::t_status   status;
    } t_dq_result;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
        logic               typed;
        t_dq_result         result;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // predicted contents of the ring
    logic [ITEM_W-1:0] deque_slots [DEPTH];
    logic [SLOT_W-1:0] head_slot    = '0;
    logic [OCC_W-1:0]  stored_count = '0;

    // expected beats in order, written and read by running counters
    t_dq_result expected_results [EXPECT_DEPTH];
    int expect_wr       = 0;
    int expect_rd       = 0;
    int mismatch_count  = 0;
    int req_idle_pct    = 0;
    int rsp_idle_pct    = 0;
    int hold_off_cycles = 0;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{dq_pkg::FUNC_POP_BACK, 32'h0, POS_W'(0), 1'b1, '{32'h0, 5'd0, dq_pkg::STATUS_EMPTY}},
        '{dq_pkg::FUNC_POP_FRONT, 32'h0, POS_W'(0), 1'b1, '{32'h0, 5'd0, dq_pkg::STATUS_EMPTY}},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(0), 1'b1, '{32'h0, 5'd0, dq_pkg::STATUS_RANGE}},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(-1), 1'b1, '{32'h0, 5'd0, dq_pkg::STATUS_RANGE}},
        '{FUNC_SPARE_A, 32'hffffffff, POS_W'(0), 1'b1, '{32'h0, 5'd0, dq_pkg::STATUS_OK}},
        '{FUNC_SPARE_B, 32'hffffffff, POS_W'(0), 1'b1, '{32'h0, 5'd0, dq_pkg::STATUS_OK}},
        '{FUNC_SPARE_C, 32'hffffffff, POS_W'(0), 1'b1, '{32'h0, 5'd0, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_PUSH_BACK, 32'hffffffff, POS_W'(0), 1'b1,
          '{32'h0, 5'd1, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_PUSH_FRONT, 32'h0, POS_W'(0), 1'b1, '{32'h0, 5'd2, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_PUSH_BACK, 32'ha5a5a5a5, POS_W'(0), 1'b1,
          '{32'h0, 5'd3, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(0), 1'b1, '{32'h0, 5'd3, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(-1), 1'b1,
          '{32'ha5a5a5a5, 5'd3, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(1), 1'b0, '0},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(-3), 1'b0, '0},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(3), 1'b1, '{32'h0, 5'd3, dq_pkg::STATUS_RANGE}},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(-4), 1'b1, '{32'h0, 5'd3, dq_pkg::STATUS_RANGE}},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(15), 1'b1, '{32'h0, 5'd3, dq_pkg::STATUS_RANGE}},
        '{dq_pkg::FUNC_READ, 32'h0, POS_W'(-16), 1'b1, '{32'h0, 5'd3, dq_pkg::STATUS_RANGE}},
        '{dq_pkg::FUNC_POP_FRONT, 32'h0, POS_W'(0), 1'b1, '{32'h0, 5'd2, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_POP_BACK, 32'h0, POS_W'(0), 1'b1,
          '{32'ha5a5a5a5, 5'd1, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_PUSH_FRONT, 32'h5a5a5a5a, POS_W'(0), 1'b1,
          '{32'h0, 5'd2, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_POP_BACK, 32'h0, POS_W'(0), 1'b1,
          '{32'hffffffff, 5'd1, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_POP_FRONT, 32'h0, POS_W'(0), 1'b1,
          '{32'h5a5a5a5a, 5'd0, dq_pkg::STATUS_OK}},
        '{dq_pkg::FUNC_PUSH_FRONT, 32'h12345678, POS_W'(0), 1'b0, '0}
    };

    function automatic t_dq_result deque_apply(input logic [FUNC_W-1:0] func,
                                               input logic [VALUE_W-1:0] value,
                                               input logic [POS_W-1:0] position);
        t_dq_result        outcome;
        logic [SLOT_W-1:0] slot;
        logic [OCC_W-1:0]  from_back;
        outcome.item   = '0;
        outcome.status = dq_pkg::STATUS_OK;
        case (func)
            dq_pkg::FUNC_PUSH_BACK: begin
                if (stored_count == DEPTH) begin
                    outcome.status = dq_pkg::STATUS_FULL;
                end else begin
                    slot = head_slot + SLOT_W'(stored_count);
                    deque_slots[slot] = value;
                    stored_count++;
                end
            end
            dq_pkg::FUNC_PUSH_FRONT: begin
                if (stored_count == DEPTH) begin
                    outcome.status = dq_pkg::STATUS_FULL;
                end else begin
                    head_slot = head_slot - 1'b1;
                    deque_slots[head_slot] = value;
                    stored_count++;
                end
            end
            dq_pkg::FUNC_POP_BACK: begin
                if (stored_count == 0) begin
                    outcome.status = dq_pkg::STATUS_EMPTY;
                end else begin
                    slot = head_slot + SLOT_W'(stored_count) - 1'b1;
                    outcome.item = deque_slots[slot];
                    stored_count--;
                end
            end
            dq_pkg::FUNC_POP_FRONT: begin
                if (stored_count == 0) begin
                    outcome.status = dq_pkg::STATUS_EMPTY;
                end else begin
                    outcome.item = deque_slots[head_slot];
                    head_slot = head_slot + 1'b1;
                    stored_count--;
                end
            end
            dq_pkg::FUNC_READ: begin
                if (!position[POS_W-1]) begin
                    if (OCC_W'(position) >= stored_count) begin
                        outcome.status = dq_pkg::STATUS_RANGE;
                    end else begin
                        slot = head_slot + SLOT_W'(position);
                        outcome.item = deque_slots[slot];
                    end
                end else begin
                    // magnitude of a negative position, 1 to 16
                    from_back = -position;
                    if (from_back > stored_count) begin
                        outcome.status = dq_pkg::STATUS_RANGE;
                    end else begin
                        slot = head_slot + SLOT_W'(stored_count - from_back);
                        outcome.item = deque_slots[slot];
                    end
                end
            end
            default: begin
            end
        endcase
        outcome.occupancy = stored_count;
        return outcome;
    endfunction

    task automatic issue_request(input logic [FUNC_W-1:0] func,
                                 input logic [VALUE_W-1:0] value,
                                 input logic [POS_W-1:0] position,
                                 input logic typed,
                                 input t_dq_result typed_result);
        t_dq_result predicted;
        while ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= func;
        req_ch.value    <= value;
        req_ch.position <= position;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        predicted = deque_apply(func, value, position);
        expected_results[expect_wr % EXPECT_DEPTH] = typed ? typed_result : predicted;
        expect_wr++;
    endtask

    task automatic drain_expected;
        req_ch.valid <= 1'b0;
        while (expect_wr != expect_rd) begin
            @(posedge i_clk);
        end
    endtask

    task automatic note_mismatch(input string what, input t_dq_result want,
                                 input t_dq_result got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s: expected %h %0d %0d, actual %h %0d %0d",
                     what, want.item, want.occupancy, want.status,
                     got.item, got.occupancy, got.status);
        end
    endtask

    always @(posedge i_clk) begin : response_check
        t_dq_result want;
        t_dq_result got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.item      = rsp_ch.item;
            got.occupancy = rsp_ch.occupancy;
            got.status    = dq_pkg::t_status'(rsp_ch.status);
            if (expect_wr == expect_rd) begin
                note_mismatch("unexpected beat", '0, got);
            end else begin
                want = expected_results[expect_rd % EXPECT_DEPTH];
                expect_rd++;
                if (got.item !== want.item || got.occupancy !== want.occupancy
                        || got.status !== want.status) begin
                    note_mismatch("wrong beat", want, got);
                end
            end
        end
    end

    initial begin : response_side
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles != 0) begin
                rsp_ch.ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
        int mix;
        int roll;
        int push_pct;
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= dq_pkg::FUNC_PUSH_BACK;
        req_ch.value    <= '0;
        req_ch.position <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            issue_request(directed_rows[r].func, directed_rows[r].value,
                          directed_rows[r].position, directed_rows[r].typed,
                          directed_rows[r].result);
        end

        mix = MIX_FILL;
        for (int phase = 0; phase < 3; phase++) begin
            req_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 56 : 0;
            rsp_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver stall so the block backs up
                if (phase == 0 && n == 120) begin
                    hold_off_cycles = HOLD_OFF_CYCLES;
                end
                if (phase == 0 && n == 400) begin
                    drain_expected();
                end
                if (n % 48 == 0) begin
                    mix = $urandom_range(MIX_BALANCE, MIX_FILL);
                end
                push_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;

                roll = $urandom_range(99);
                if (roll < 2) begin
                    func = FUNC_W'($urandom_range(FUNC_SPARE_C, FUNC_SPARE_A));
                end else if (roll < 24) begin
                    func = dq_pkg::FUNC_READ;
                end else if ($urandom_range(99) < push_pct) begin
                    func = $urandom_range(1) ? dq_pkg::FUNC_PUSH_FRONT
                                             : dq_pkg::FUNC_PUSH_BACK;
                end else begin
                    func = $urandom_range(1) ? dq_pkg::FUNC_POP_FRONT
                                             : dq_pkg::FUNC_POP_BACK;
                end

                case ($urandom_range(15))
                    0: value = '0;
                    1: value = '1;
                    default: value = $urandom;
                endcase

                if (stored_count != 0 && $urandom_range(3) != 0) begin
                    if ($urandom_range(1)) begin
                        position = POS_W'($urandom_range(stored_count - 1));
                    end else begin
                        position = POS_W'(-int'($urandom_range(stored_count, 1)));
                    end
                end else begin
                    position = POS_W'($urandom_range(31));
                end

                issue_request(func, value, position, 1'b0, '0);
            end
        end

        drain_expected();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        mismatch_count += expect_wr - expect_rd;
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
